[rtl/core/dmem_pkg.sv]
// shared widths and pipeline payload types for the dual mesh edge metrics unit
// no dependencies
package dmem_pkg;

    localparam int COORD_W  = 24;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int SQ_W     = 2 * DIFF_W;
    localparam int RAD_W    = SQ_W;
    localparam int ROOT_W   = RAD_W / 2;
    localparam int REM_W    = ROOT_W + 1;
    localparam int AREA_W   = SQ_W + 2;
    localparam int AREA_SH  = 13;
    localparam int NODE_SH  = 14;
    localparam int LEN_W    = 26;
    localparam int NRM_W    = 26;
    localparam int AADD_W   = 41;
    localparam int NADD_W   = 39;
    localparam int IN_DW    = 8 * COORD_W;
    localparam int IN_UW    = 2;
    localparam int OUT_DW   = 280;

    // results that ride alongside the square root stages
    typedef struct packed {
        logic signed [NRM_W-1:0]  dual_nx;
        logic signed [NRM_W-1:0]  dual_ny;
        logic signed [NRM_W-1:0]  primal_nx;
        logic signed [NRM_W-1:0]  primal_ny;
        logic signed [AADD_W-1:0] left_area_add;
        logic signed [AADD_W-1:0] right_area_add;
    } t_carry;

    // one bit-per-stage square root lane
    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } t_root_lane;

endpackage

[rtl/core/dual_mesh_edge_metrics_unit.sv]
// top level of the dual mesh edge metrics unit: geometry front end, square roots, node addend
// depends on dmem_pkg
//
// One edge per cycle enters while the pipeline advances and one result per edge leaves,
// in order. The first three stages select the midpoint for absent neighbours and form
// differences, then the squares and area products, then the sums; 25 stages of a
// one-bit-per-stage square root follow, running edge and dual lengths side by side;
// the last stage multiplies h by l and holds the result. The whole pipeline advances
// whenever the output register is empty or being taken, so o_s_tready follows
// i_m_tready while a result is waiting.
module dual_mesh_edge_metrics_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    // node_c_x, node_c_y, node_d_x, node_d_y, left_cx, left_cy, right_cx, right_cy
    input  logic [dmem_pkg::IN_DW-1:0]   i_s_tdata,
    // has_left, has_right
    input  logic [dmem_pkg::IN_UW-1:0]   i_s_tuser,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    // edge_length, dual_length, dual_nx, dual_ny, primal_nx, primal_ny,
    // left_area_add, right_area_add, node_area_add, zero fill
    output logic [dmem_pkg::OUT_DW-1:0]  o_m_tdata
);
    import dmem_pkg::*;

    localparam int NSTG = ROOT_W;

    logic en;

    // stage 1 registers
    logic                     r_v1;
    logic signed [DIFF_W-1:0] r_dxh, r_dyh, r_dxl, r_dyl;
    logic signed [DIFF_W-1:0] r_ae1, r_af1, r_ae2, r_af2, r_ae3, r_af3;
    logic signed [DIFF_W-1:0] r_be1, r_bf1, r_be2, r_bf2;
    logic                     r_ha1, r_hb1;
    logic signed [NRM_W-1:0]  r_dnx1, r_dny1, r_pnx1, r_pny1;

    // stage 2 registers
    logic                     r_v2;
    logic [SQ_W-2:0]          r_sqhx, r_sqhy, r_sqlx, r_sqly;
    logic signed [SQ_W-1:0]   r_ap1, r_ap2, r_ap3, r_bp1, r_bp2;
    logic                     r_ha2, r_hb2;
    logic signed [NRM_W-1:0]  r_dnx2, r_dny2, r_pnx2, r_pny2;

    // square root pipeline
    logic       r_vq  [NSTG+1];
    t_root_lane r_lh  [NSTG+1];
    t_root_lane r_ll  [NSTG+1];
    t_carry     r_cq  [NSTG+1];
    t_root_lane n_lh  [NSTG];
    t_root_lane n_ll  [NSTG];

    // output register
    logic                     r_vo;
    logic [LEN_W-1:0]         r_h, r_l;
    logic [NADD_W-1:0]        r_node;
    t_carry                   r_co;

    assign en         = !r_vo || i_m_tready;
    assign o_s_tready = en;
    assign o_m_tvalid = r_vo;
    assign o_m_tdata  = {3'b000, r_node, r_co.right_area_add, r_co.left_area_add,
                         r_co.primal_ny, r_co.primal_nx, r_co.dual_ny, r_co.dual_nx,
                         r_l, r_h};

    // stage 1: unpack, midpoint substitution, differences
    logic signed [COORD_W-1:0] xc, yc, xd, yd, xa, ya, xb, yb, mx, my;
    logic signed [DIFF_W-1:0]  sx, sy;
    logic                      ha, hb;

    always_comb begin
        xc = i_s_tdata[0*COORD_W +: COORD_W];
        yc = i_s_tdata[1*COORD_W +: COORD_W];
        xd = i_s_tdata[2*COORD_W +: COORD_W];
        yd = i_s_tdata[3*COORD_W +: COORD_W];
        ha = i_s_tuser[0];
        hb = i_s_tuser[1];
        sx = {xc[COORD_W-1], xc} + {xd[COORD_W-1], xd};
        sy = {yc[COORD_W-1], yc} + {yd[COORD_W-1], yd};
        mx = sx[DIFF_W-1:1];
        my = sy[DIFF_W-1:1];
        xa = ha ? i_s_tdata[4*COORD_W +: COORD_W] : mx;
        ya = ha ? i_s_tdata[5*COORD_W +: COORD_W] : my;
        xb = hb ? i_s_tdata[6*COORD_W +: COORD_W] : mx;
        yb = hb ? i_s_tdata[7*COORD_W +: COORD_W] : my;
    end

    function automatic logic signed [DIFF_W-1:0] sub(input logic signed [COORD_W-1:0] p,
                                                     input logic signed [COORD_W-1:0] q);
        sub = {p[COORD_W-1], p} - {q[COORD_W-1], q};
    endfunction

    function automatic logic signed [DIFF_W-1:0] add(input logic signed [COORD_W-1:0] p,
                                                     input logic signed [COORD_W-1:0] q);
        add = {p[COORD_W-1], p} + {q[COORD_W-1], q};
    endfunction

    function automatic logic signed [NRM_W-1:0] ext(input logic signed [DIFF_W-1:0] p);
        ext = {p[DIFF_W-1], p};
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_s_tvalid;
        end
        if (en) begin
            r_dxh  <= sub(xc, xd);
            r_dyh  <= sub(yc, yd);
            r_dxl  <= sub(xa, xb);
            r_dyl  <= sub(ya, yb);
            r_ae1  <= sub(xd, xa);
            r_af1  <= add(yd, ya);
            r_ae2  <= sub(xa, xc);
            r_af2  <= add(ya, yc);
            r_ae3  <= sub(xc, xd);
            r_af3  <= add(yc, yd);
            r_be1  <= sub(xd, xb);
            r_bf1  <= add(yd, yb);
            r_be2  <= sub(xb, xc);
            r_bf2  <= add(yb, yc);
            r_ha1  <= ha;
            r_hb1  <= hb;
            r_dnx1 <= ext(sub(ya, yb));
            r_dny1 <= ext(sub(xb, xa));
            r_pnx1 <= ext(sub(yc, yd));
            r_pny1 <= ext(sub(xd, xc));
        end
    end

    // stage 2: squares and area products
    logic signed [SQ_W-1:0] p_hx, p_hy, p_lx, p_ly;

    always_comb begin
        p_hx = r_dxh * r_dxh;
        p_hy = r_dyh * r_dyh;
        p_lx = r_dxl * r_dxl;
        p_ly = r_dyl * r_dyl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v2 <= r_v1;
        end
        if (en) begin
            r_sqhx <= p_hx[SQ_W-2:0];
            r_sqhy <= p_hy[SQ_W-2:0];
            r_sqlx <= p_lx[SQ_W-2:0];
            r_sqly <= p_ly[SQ_W-2:0];
            r_ap1  <= r_ae1 * r_af1;
            r_ap2  <= r_ae2 * r_af2;
            r_ap3  <= r_ae3 * r_af3;
            r_bp1  <= r_be1 * r_bf1;
            r_bp2  <= r_be2 * r_bf2;
            r_ha2  <= r_ha1;
            r_hb2  <= r_hb1;
            r_dnx2 <= r_dnx1;
            r_dny2 <= r_dny1;
            r_pnx2 <= r_pnx1;
            r_pny2 <= r_pny1;
        end
    end

    // stage 3: sums, area halving and conversion, root lane setup
    logic signed [AREA_W-1:0] ta, tb, ntb;
    t_carry                   c3;
    t_root_lane               lh0, ll0;

    function automatic logic signed [AREA_W-1:0] sx2(input logic signed [SQ_W-1:0] p);
        sx2 = {{2{p[SQ_W-1]}}, p};
    endfunction

    always_comb begin
        ta  = sx2(r_ap1) + sx2(r_ap2) + sx2(r_ap3);
        tb  = sx2(r_bp1) + sx2(r_bp2) + sx2(r_ap3);
        ntb = -tb;
        c3.dual_nx   = r_dnx2;
        c3.dual_ny   = r_dny2;
        c3.primal_nx = r_pnx2;
        c3.primal_ny = r_pny2;
        c3.left_area_add  = r_ha2 ? {{2{ta[AREA_W-1]}}, ta[AREA_W-1:AREA_SH]}
                                  : '0;
        c3.right_area_add = r_hb2 ? {{2{ntb[AREA_W-1]}}, ntb[AREA_W-1:AREA_SH]}
                                  : '0;
        lh0.rad  = {1'b0, r_sqhx} + {1'b0, r_sqhy};
        lh0.rem  = '0;
        lh0.root = '0;
        ll0.rad  = {1'b0, r_sqlx} + {1'b0, r_sqly};
        ll0.rem  = '0;
        ll0.root = '0;
    end

    // one root bit per stage
    function automatic t_root_lane root_step(input t_root_lane s);
        logic [REM_W+1:0] cur;
        logic [REM_W+1:0] trial;
        t_root_lane       o;
        cur   = {s.rem, s.rad[RAD_W-1 -: 2]};
        trial = {1'b0, s.root, 2'b01};
        o.rad = {s.rad[RAD_W-3:0], 2'b00};
        if (cur >= trial) begin
            o.rem  = REM_W'(cur - trial);
            o.root = {s.root[ROOT_W-2:0], 1'b1};
        end else begin
            o.rem  = cur[REM_W-1:0];
            o.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        root_step = o;
    endfunction

    always_comb begin
        for (int i = 0; i < NSTG; i++) begin
            n_lh[i] = root_step(r_lh[i]);
            n_ll[i] = root_step(r_ll[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= NSTG; i++) begin
                r_vq[i] <= 1'b0;
            end
        end else if (en) begin
            r_vq[0] <= r_v2;
            for (int i = 1; i <= NSTG; i++) begin
                r_vq[i] <= r_vq[i-1];
            end
        end
        if (en) begin
            r_lh[0] <= lh0;
            r_ll[0] <= ll0;
            r_cq[0] <= c3;
            for (int i = 1; i <= NSTG; i++) begin
                r_lh[i] <= n_lh[i-1];
                r_ll[i] <= n_ll[i-1];
                r_cq[i] <= r_cq[i-1];
            end
        end
    end

    // output stage: node addend from h times l
    logic [2*ROOT_W-1:0] hl;

    always_comb begin
        hl = r_lh[NSTG].root * r_ll[NSTG].root;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (en) begin
            r_vo <= r_vq[NSTG];
        end
        if (en) begin
            r_h    <= LEN_W'(r_lh[NSTG].root);
            r_l    <= LEN_W'(r_ll[NSTG].root);
            r_node <= NADD_W'(hl[2*ROOT_W-1:NODE_SH]);
            r_co   <= r_cq[NSTG];
        end
    end

endmodule

[tb/sv/dual_mesh_edge_metrics_unit_test.sv]
// self-checking testbench for the dual mesh edge metrics unit: directed and random edges
// driven over the stream ports, results predicted in a small scoreboard class
// depends on dmem_pkg and dual_mesh_edge_metrics_unit
module dual_mesh_edge_metrics_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dmem_pkg::*;

    localparam int LATENCY     = 29;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int RANDOM_EDGES = 522;

    localparam longint S26_LO = -64'sd33554432;
    localparam longint S26_HI = 64'sd33554431;
    localparam longint S41_LO = -64'sd1099511627776;
    localparam longint S41_HI = 64'sd1099511627775;
    localparam longint unsigned LEN_MAX  = 64'd67108863;
    localparam longint unsigned NADD_MAX = 64'd549755813887;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_s_tvalid;
    logic                o_s_tready;
    logic [IN_DW-1:0]    i_s_tdata;
    logic [IN_UW-1:0]    i_s_tuser;
    logic                o_m_tvalid;
    logic                i_m_tready;
    logic [OUT_DW-1:0]   o_m_tdata;

    // idling modes and receiver hold-off
    int sender_idle_pct;
    int receiver_idle_pct;
    int hold_off_cycles;
    longint cycle_count;

    dual_mesh_edge_metrics_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // predicts edge geometry and holds the results still owed by the unit
    class edge_metrics_scoreboard;
        logic [OUT_DW-1:0] pending_results[$];
        int                failures;
        string             field_name[9];
        int                field_lo[9];
        int                field_w[9];

        function new();
            field_name = '{"edge_length", "dual_length", "dual_nx", "dual_ny", "primal_nx",
                           "primal_ny", "left_area_add", "right_area_add", "node_area_add"};
            field_w    = '{26, 26, 26, 26, 26, 26, 41, 41, 39};
            field_lo[0] = 0;
            for (int i = 1; i < 9; i++) field_lo[i] = field_lo[i-1] + field_w[i-1];
            failures = 0;
        endfunction

        // floored integer square root, one result bit per round
        function longint unsigned floor_root(longint unsigned v);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function longint clamp(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        // twice the signed triangle area of c, d and p
        function longint twice_area(longint xc, longint yc, longint xd, longint yd,
                                    longint xp, longint yp);
            return (xd - xp) * (yd + yp) + (xp - xc) * (yp + yc) + (xc - xd) * (yc + yd);
        endfunction

        function void note_input(logic [IN_DW-1:0] d, logic [IN_UW-1:0] u);
            longint xc, yc, xd, yd, xa, ya, xb, yb, mx, my;
            longint left_add, right_add;
            longint unsigned h, l, node_add;
            logic [25:0] dnx, dny, pnx, pny;
            xc = $signed(d[23:0]);
            yc = $signed(d[47:24]);
            xd = $signed(d[71:48]);
            yd = $signed(d[95:72]);
            mx = (xc + xd) >>> 1;
            my = (yc + yd) >>> 1;
            xa = u[0] ? longint'($signed(d[119:96]))  : mx;
            ya = u[0] ? longint'($signed(d[143:120])) : my;
            xb = u[1] ? longint'($signed(d[167:144])) : mx;
            yb = u[1] ? longint'($signed(d[191:168])) : my;
            h = floor_root((xc - xd) * (xc - xd) + (yc - yd) * (yc - yd));
            l = floor_root((xa - xb) * (xa - xb) + (ya - yb) * (ya - yb));
            if (h > LEN_MAX) h = LEN_MAX;
            if (l > LEN_MAX) l = LEN_MAX;
            left_add  = 0;
            right_add = 0;
            if (u[0])
                left_add = clamp(twice_area(xc, yc, xd, yd, xa, ya) >>> 13, S41_LO, S41_HI);
            if (u[1])
                right_add = clamp((-twice_area(xc, yc, xd, yd, xb, yb)) >>> 13,
                                  S41_LO, S41_HI);
            node_add = (h * l) >> 14;
            if (node_add > NADD_MAX) node_add = NADD_MAX;
            dnx = 26'(clamp(ya - yb, S26_LO, S26_HI));
            dny = 26'(clamp(xb - xa, S26_LO, S26_HI));
            pnx = 26'(clamp(yc - yd, S26_LO, S26_HI));
            pny = 26'(clamp(xd - xc, S26_LO, S26_HI));
            pending_results.push_back({3'b0, node_add[38:0], right_add[40:0], left_add[40:0],
                                       pny, pnx, dny, dnx, l[25:0], h[25:0]});
        endfunction

        function void check_result(logic [OUT_DW-1:0] d);
            logic [OUT_DW-1:0] e;
            logic [63:0] ev, av;
            if (pending_results.size() == 0) begin
                $error("unexpected result transaction %h", d);
                failures++;
                return;
            end
            e = pending_results.pop_front();
            for (int i = 0; i < 9; i++) begin
                ev = 64'(e >> field_lo[i]) & ((64'd1 << field_w[i]) - 64'd1);
                av = 64'(d >> field_lo[i]) & ((64'd1 << field_w[i]) - 64'd1);
                if (ev != av) begin
                    $error("%s: expected %h, got %h", field_name[i], ev, av);
                    failures++;
                end
            end
        endfunction
    endclass

    edge_metrics_scoreboard scoreboard;

    // clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver readiness, with a counted hold-off when asked
    always @(negedge i_clk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // result checking
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) scoreboard.check_result(o_m_tdata);
    end

    // one edge transaction, with a random idle gap ahead of it
    task automatic send_edge(input logic [IN_DW-1:0] d, input logic [IN_UW-1:0] u);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= d;
        i_s_tuser  <= u;
        do @(posedge i_clk); while (!o_s_tready);
        scoreboard.note_input(d, u);
        @(negedge i_clk);
    endtask

    task automatic send_coords(input logic [23:0] xc, yc, xd, yd, xa, ya, xb, yb,
                               input logic [1:0] u);
        send_edge({yb, xb, ya, xa, yd, xd, yc, xc}, u);
    endtask

    // coordinate, mostly full range, sometimes a small mesh-like value
    function automatic logic [23:0] rand_coord();
        if ($urandom_range(3) == 0) return 24'($signed($urandom_range(8191)) - 4096);
        return 24'($urandom);
    endfunction

    // well-formed edge: a near b-c-d geometry, or fully random noise
    task automatic send_random_edge();
        logic [23:0] c[8];
        logic [1:0] u;
        for (int i = 0; i < 8; i++) c[i] = rand_coord();
        u = 2'($urandom);
        if ($urandom_range(3) != 0) begin
            for (int i = 2; i < 8; i++)
                c[i] = c[i % 2] + 24'($signed($urandom_range(65535)) - 32768);
        end
        send_coords(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], u);
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (scoreboard.pending_results.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    localparam logic [23:0] CMAX = 24'h7fffff;
    localparam logic [23:0] CMIN = 24'h800000;

    initial begin
        scoreboard        = new();
        cycle_count       = 0;
        hold_off_cycles   = 0;
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = '0;
        i_m_tready = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: extremes, absent neighbours, odd negative midpoint, degenerate edge
        send_coords(CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMAX, CMIN, 2'b11);
        send_coords(CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMIN, CMAX, 2'b11);
        send_coords(CMIN, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMAX, 2'b11);
        send_coords(CMAX, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMIN, 2'b00);
        send_coords(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 2'b11);
        send_coords(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 2'b11);
        send_coords('0, '0, '0, '0, '0, '0, '0, '0, 2'b00);
        send_coords(24'hffffff, 24'hfffffd, 24'h000000, 24'h000000, CMAX, CMIN,
                    CMIN, CMAX, 2'b00);
        send_coords(24'hffffff, 24'hfffffd, 24'h000000, 24'h000000, CMAX, CMIN,
                    CMIN, CMAX, 2'b01);
        send_coords(24'hffffff, 24'hfffffd, 24'h000000, 24'h000000, CMAX, CMIN,
                    CMIN, CMAX, 2'b10);
        send_coords(24'h001000, 24'h000000, 24'h000000, 24'h001000, 24'h000800,
                    24'h000800, 24'hfff800, 24'hfff800, 2'b11);
        send_coords(24'h001000, 24'h000000, 24'h000000, 24'h001000, 24'h000800,
                    24'h000800, 24'hfff800, 24'hfff800, 2'b01);
        send_coords(24'h001000, 24'h000000, 24'h000000, 24'h001000, 24'h000800,
                    24'h000800, 24'hfff800, 24'hfff800, 2'b10);
        send_coords(24'h000001, 24'h000001, 24'h000002, 24'h000002, 24'h000001,
                    24'h000002, 24'h000002, 24'h000001, 2'b11);
        send_coords(CMAX, 24'h0, CMIN, 24'h0, 24'h0, CMAX, 24'h0, CMIN, 2'b11);
        send_coords(24'h0, CMAX, 24'h0, CMIN, CMAX, 24'h0, CMIN, 24'h0, 2'b10);
        send_coords(24'h555555, 24'haaaaaa, 24'haaaaaa, 24'h555555, 24'h555555,
                    24'h555555, 24'haaaaaa, 24'haaaaaa, 2'b11);

        // pause until every result is back
        wait_drained();

        // random, sender idles less than receiver
        sender_idle_pct   = 21;
        receiver_idle_pct = 64;
        repeat (RANDOM_EDGES / 3) send_random_edge();

        // long receiver hold-off so the pipeline fills and stalls its input
        hold_off_cycles = 200;
        repeat (60) send_random_edge();

        // the other way round
        sender_idle_pct   = 64;
        receiver_idle_pct = 21;
        repeat (RANDOM_EDGES / 3) send_random_edge();

        // no idling on either side
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        repeat (RANDOM_EDGES / 3) send_random_edge();

        wait_drained();
        if (scoreboard.failures == 0 && scoreboard.pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/dmem_pkg.sv
rtl/core/dual_mesh_edge_metrics_unit.sv
tb/sv/dual_mesh_edge_metrics_unit_test.sv
